@@ rtl/core/lzjb_pkg.sv @@
// lzjb decompressor shared constants and types
`default_nettype none

package lzjb_pkg;

   localparam int HIST_DEPTH     = 1024;
   localparam int HIST_AW        = $clog2(HIST_DEPTH);
   localparam int LANE_BYTES     = 8;
   localparam int LANE_AW        = $clog2(LANE_BYTES);
   localparam int LEN_FIELD_BITS = 6;
   localparam int LEN_BIAS       = 3;
   localparam int OFFSET_BITS    = 16 - LEN_FIELD_BITS;
   localparam int COUNT_BITS     = 11;
   localparam int COUNT_CAP      = 1024;
   localparam int LEN_BITS       = 7;
   localparam int DATA_BITS      = LANE_BYTES * 8;
   localparam int RSP_TDATA_W    = ((DATA_BITS + 4 + 7) / 8) * 8;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_MAP_END   = 3'd1,
      STATUS_TRUNC     = 3'd2,
      STATUS_BEYOND    = 3'd3,
      STATUS_ZERO_OFS  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_DATA = 2'd2
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/lzjb_stream_decompressor.sv @@
// lzjb stream decompressor: byte-serial decoder with history memory
//
// req channel: one compressed byte per transfer, req_tlast marks the final
// byte of a stream. rsp channel: up to eight decoded bytes per transfer with
// byte count, rsp_tlast on the last result of an input byte, and stream
// done plus status in rsp_tuser.
// a map byte or a first match byte gives no result unless the stream ends
// there; a literal's result is registered and shown in the cycle after the
// transfer. a match of 3 to 66 bytes is copied through the 1024-byte
// history memory byte by byte (registered read, then write and pack), and
// the copy holds while the output stalls.
// req_tready is low while a match is copied or a waiting result is not taken.
// when the receiver stalls, the copy holds until the pending result is taken.
// reset clears the control state and rsp_tvalid but not the data registers;
// the history is never read before it is written, so it needs no clearing.
`default_nettype none

module lzjb_stream_decompressor import lzjb_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // in_byte
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,   // out_bytes, byte_count, zero pad
   output logic                        rsp_tlast,
   output logic [3:0]                  rsp_tuser    // stream_done, status
);

   logic [7:0]            hist_mem [HIST_DEPTH];
   logic [7:0]            rdata_ff;

   state_type             state_ff, state_in;
   logic [HIST_AW-1:0]    wp_ff, wp_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [7:0]            map_ff, map_in;
   logic [2:0]            bit_ff, bit_in;
   logic                  need_map_ff, need_map_in;
   logic                  pend_ff, pend_in;
   logic [7:0]            high_ff, high_in;
   logic                  err_ff, err_in;
   logic                  last_ff, last_in;
   logic [LEN_BITS-1:0]   remain_ff, remain_in;
   logic [HIST_AW-1:0]    src_ff, src_in;
   logic [DATA_BITS-1:0]  acc_ff, acc_in;
   logic [LANE_AW-1:0]    lane_ff, lane_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]  rsp_bytes_ff, rsp_bytes_in;
   logic [3:0]            rsp_count_ff, rsp_count_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_done_ff, rsp_done_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  slot_free;
   logic                  accept;
   logic                  step;
   logic                  final_byte;
   logic [OFFSET_BITS-1:0] offset;
   logic                  match_ok;
   logic                  mem_we;
   logic [HIST_AW-1:0]    mem_waddr;
   logic [7:0]            mem_wdata;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign step       = (state_ff == ST_DATA) && slot_free;
   assign final_byte = (remain_ff == LEN_BITS'(1));
   assign offset     = {high_ff[OFFSET_BITS-9:0], req_tdata};
   assign match_ok   = (offset != '0) && ({1'b0, offset} <= cnt_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !err_ff && pend_ff && match_ok) state_in = ST_READ;
         end
         ST_READ: state_in = ST_DATA;
         ST_DATA: begin
            if (step) state_in = final_byte ? ST_IDLE : ST_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wp_in         = wp_ff;
      cnt_in        = cnt_ff;
      map_in        = map_ff;
      bit_in        = bit_ff;
      need_map_in   = need_map_ff;
      pend_in       = pend_ff;
      high_in       = high_ff;
      err_in        = err_ff;
      last_in       = last_ff;
      remain_in     = remain_ff;
      src_in        = src_ff;
      acc_in        = acc_ff;
      lane_in       = lane_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = wp_ff;
      mem_wdata     = req_tdata;

      if (accept) begin
         if (err_ff) begin
            if (req_tlast) begin
               cnt_in = '0; map_in = '0; bit_in = 3'd7; need_map_in = 1'b1;
               pend_in = 1'b0; high_in = '0; err_in = 1'b0;
            end
         end else if (pend_ff) begin
            pend_in = 1'b0;
            if (!match_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_bytes_in  = '0;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_done_in   = 1'b1;
               rsp_status_in = (offset == '0) ? STATUS_ZERO_OFS : STATUS_BEYOND;
               if (req_tlast) begin
                  cnt_in = '0; map_in = '0; bit_in = 3'd7; need_map_in = 1'b1;
                  high_in = '0;
               end else begin
                  err_in = 1'b1;
               end
            end else begin
               remain_in = LEN_BITS'(high_ff[7:8-LEN_FIELD_BITS]) + LEN_BITS'(LEN_BIAS);
               src_in    = wp_ff - HIST_AW'(offset);
               last_in   = req_tlast;
               acc_in    = '0;
               lane_in   = '0;
            end
         end else if (need_map_ff) begin
            map_in      = req_tdata;
            bit_in      = '0;
            need_map_in = 1'b0;
            if (req_tlast) begin
               rsp_valid_in  = 1'b1;
               rsp_bytes_in  = '0;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_done_in   = 1'b1;
               rsp_status_in = STATUS_MAP_END;
               cnt_in = '0; map_in = '0; bit_in = 3'd7; need_map_in = 1'b1;
            end
         end else if (map_ff[bit_ff]) begin
            if (req_tlast) begin
               rsp_valid_in  = 1'b1;
               rsp_bytes_in  = '0;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_done_in   = 1'b1;
               rsp_status_in = STATUS_TRUNC;
               cnt_in = '0; map_in = '0; bit_in = 3'd7; need_map_in = 1'b1;
            end else begin
               pend_in = 1'b1;
               high_in = req_tdata;
            end
         end else begin
            mem_we    = 1'b1;
            mem_waddr = wp_ff;
            mem_wdata = req_tdata;
            wp_in     = wp_ff + 1'b1;
            if (cnt_ff < COUNT_BITS'(COUNT_CAP)) cnt_in = cnt_ff + 1'b1;
            if (bit_ff == 3'd7) need_map_in = 1'b1;
            else bit_in = bit_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_bytes_in  = {{(DATA_BITS-8){1'b0}}, req_tdata};
            rsp_count_in  = 4'd1;
            rsp_last_in   = 1'b1;
            rsp_done_in   = req_tlast;
            rsp_status_in = STATUS_OK;
            if (req_tlast) begin
               cnt_in = '0; map_in = '0; bit_in = 3'd7; need_map_in = 1'b1;
            end
         end
      end

      if (step) begin
         mem_we    = 1'b1;
         mem_waddr = wp_ff;
         mem_wdata = rdata_ff;
         wp_in     = wp_ff + 1'b1;
         src_in    = src_ff + 1'b1;
         remain_in = remain_ff - 1'b1;
         if (cnt_ff < COUNT_BITS'(COUNT_CAP)) cnt_in = cnt_ff + 1'b1;
         acc_in = acc_ff;
         acc_in[{lane_ff, 3'b000} +: 8] = rdata_ff;
         lane_in = lane_ff + 1'b1;
         if (final_byte || (lane_ff == LANE_AW'(LANE_BYTES - 1))) begin
            rsp_valid_in  = 1'b1;
            rsp_bytes_in  = acc_in;
            rsp_count_in  = 4'(lane_ff) + 4'd1;
            rsp_last_in   = final_byte;
            rsp_done_in   = final_byte && last_ff;
            rsp_status_in = STATUS_OK;
            acc_in        = '0;
            lane_in       = '0;
         end
         if (final_byte) begin
            if (bit_ff == 3'd7) need_map_in = 1'b1;
            else bit_in = bit_ff + 1'b1;
            if (last_ff) begin
               cnt_in = '0; map_in = '0; bit_in = 3'd7; need_map_in = 1'b1;
               pend_in = 1'b0; high_in = '0; err_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
      if (state_ff == ST_READ) rdata_ff <= hist_mem[src_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         map_ff       <= '0;
         bit_ff       <= 3'd7;
         need_map_ff  <= 1'b1;
         pend_ff      <= 1'b0;
         high_ff      <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         map_ff       <= map_in;
         bit_ff       <= bit_in;
         need_map_ff  <= need_map_in;
         pend_ff      <= pend_in;
         high_ff      <= high_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      remain_ff     <= remain_in;
      src_ff        <= src_in;
      acc_ff        <= acc_in;
      lane_ff       <= lane_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-DATA_BITS-4){1'b0}}, rsp_count_ff, rsp_bytes_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_done_ff};

endmodule

`default_nettype wire
